// File: src/bmpcdc_pkg.sv
// bmpcdc_pkg: shared types, register codes and the 5-to-8 bit expansion table
// for the bmp row color depth converter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bmpcdc_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int WIDTH_BITS = 13;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 2'd1;

    // conversion modes
    localparam logic MODE_TO555 = 1'b0;
    localparam logic MODE_TO888 = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

    // floor(x * 255 / 31) for every 5-bit x, entry 0 leftmost
    localparam logic [0:31][7:0] EXPAND5_LUT = {
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // one finished pixel: up to three data bytes, then zero padding
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [2:0]      count;
        logic            row_end;
    } job_t;

endpackage

`default_nettype wire

// File: src/bmpcdc_front.sv
// bmpcdc_front: configuration registers, row and pixel tracking, pixel packing
// depends on bmpcdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmpcdc_front #(
    parameter int MAX_WIDTH = bmpcdc_pkg::MAX_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [bmpcdc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire  [bmpcdc_pkg::WIDTH_BITS-1:0]    cfg_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [7:0]                           s_in_byte,
    input  wire                                  q_full,
    output logic                                 q_push,
    output bmpcdc_pkg::job_t                     q_job
);

    localparam int CW = $clog2(MAX_WIDTH * 3 + 4);

    logic                              mode_reg, mode_next;
    logic [bmpcdc_pkg::WIDTH_BITS-1:0] width_reg, width_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [1:0]                        phase_reg, phase_next;
    logic [15:0]                       held_reg, held_next;

    logic [31:0]   w32;
    logic [CW-1:0] w_c;
    logic [CW-1:0] data_len;
    logic [CW-1:0] src_len;
    logic [CW-1:0] cnt_inc;
    logic [1:0]    src_pad;
    logic [1:0]    out_len_lo;
    logic [1:0]    out_pad;
    logic          accept;
    logic          in_range;
    logic          done;
    logic          last_pix;
    logic [15:0]   word;

    // clamp the row width into the supported range
    always_comb begin
        w32 = 32'(width_reg);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
    end

    assign w_c        = CW'(w32);
    assign data_len   = (mode_reg == bmpcdc_pkg::MODE_TO555) ? (w_c + (w_c << 1)) : (w_c << 1);
    assign src_pad    = 2'(3'd4 - {1'b0, data_len[1:0]});
    assign src_len    = data_len + CW'(src_pad);
    assign out_len_lo = (mode_reg == bmpcdc_pkg::MODE_TO555) ? {w_c[0], 1'b0}
                                                             : 2'(w_c[1:0] + {w_c[0], 1'b0});
    assign out_pad    = 2'(3'd4 - {1'b0, out_len_lo});

    assign s_ready  = ~q_full;
    assign accept   = s_valid & s_ready;
    assign in_range = cnt_reg < data_len;
    assign done     = in_range & ((mode_reg == bmpcdc_pkg::MODE_TO555) ? (phase_reg == 2'd2)
                                                                       : (phase_reg == 2'd1));
    assign last_pix = cnt_reg == (data_len - CW'(1));
    assign cnt_inc  = cnt_reg + CW'(1);
    assign word     = {s_in_byte, held_reg[7:0]};

    // pack the finished pixel
    always_comb begin
        q_job = '0;
        if (mode_reg == bmpcdc_pkg::MODE_TO555) begin
            q_job.data[0] = {held_reg[13:11], held_reg[7:3]};
            q_job.data[1] = {1'b0, s_in_byte[7:3], held_reg[15:14]};
            q_job.data[2] = 8'd0;
            q_job.count   = 3'd2 + {1'b0, (last_pix ? out_pad : 2'd0)};
        end else begin
            q_job.data[0] = bmpcdc_pkg::EXPAND5_LUT[word[4:0]];
            q_job.data[1] = bmpcdc_pkg::EXPAND5_LUT[word[9:5]];
            q_job.data[2] = bmpcdc_pkg::EXPAND5_LUT[word[14:10]];
            q_job.count   = 3'd3 + {1'b0, (last_pix ? out_pad : 2'd0)};
        end
        q_job.row_end = last_pix;
    end

    assign q_push = accept & done;

    always_comb begin
        mode_next  = mode_reg;
        width_next = width_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (cfg_wr_en) begin
            if (cfg_index == bmpcdc_pkg::REG_MODE) begin
                mode_next  = cfg_data[0];
                cnt_next   = '0;
                phase_next = 2'd0;
                held_next  = 16'd0;
            end else if (cfg_index == bmpcdc_pkg::REG_WIDTH) begin
                width_next = cfg_data;
                cnt_next   = '0;
                phase_next = 2'd0;
                held_next  = 16'd0;
            end
        end else if (accept) begin
            if (in_range) begin
                if (done) begin
                    phase_next = 2'd0;
                    held_next  = 16'd0;
                end else if (phase_reg == 2'd0) begin
                    phase_next = 2'd1;
                    held_next  = {8'd0, s_in_byte};
                end else begin
                    phase_next = 2'd2;
                    held_next  = {s_in_byte, held_reg[7:0]};
                end
            end
            // source padding bytes only advance the count
            if (cnt_inc >= src_len) begin
                cnt_next   = '0;
                phase_next = 2'd0;
                held_next  = 16'd0;
            end else begin
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= bmpcdc_pkg::MODE_TO555;
            width_reg <= bmpcdc_pkg::WIDTH_BITS'(1);
            cnt_reg   <= '0;
            phase_reg <= 2'd0;
            held_reg  <= 16'd0;
        end else begin
            mode_reg  <= mode_next;
            width_reg <= width_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bmpcdc_queue.sv
// bmpcdc_queue: short pixel queue between the front and back parts
// depends on bmpcdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmpcdc_queue (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  bmpcdc_pkg::job_t   push_job,
    output logic               full,
    input  wire                pop,
    output logic               head_valid,
    output bmpcdc_pkg::job_t   head_job
);

    localparam int PW = bmpcdc_pkg::QPTR_BITS;

    bmpcdc_pkg::job_t slots_reg [bmpcdc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == (PW+1)'(bmpcdc_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/bmpcdc_back.sv
// bmpcdc_back: sends each queued pixel out one byte per beat, then row padding
// depends on bmpcdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bmpcdc_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                head_valid,
    input  bmpcdc_pkg::job_t   head_job,
    output logic               pop,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_row_end,
    output logic               m_last
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       row_end_reg, row_end_next;
    logic       last_reg, last_next;
    logic       load;
    logic       final_beat;

    assign load       = head_valid & (~valid_reg | m_ready);
    assign final_beat = idx_reg == (head_job.count - 3'd1);
    assign pop        = load & final_beat;

    always_comb begin
        idx_next     = idx_reg;
        valid_next   = valid_reg & ~m_ready;
        byte_next    = byte_reg;
        row_end_next = row_end_reg;
        last_next    = last_reg;
        if (load) begin
            valid_next   = 1'b1;
            // past the data bytes only zero padding remains
            byte_next    = (idx_reg < 3'd3) ? head_job.data[idx_reg[1:0]] : 8'd0;
            row_end_next = final_beat & head_job.row_end;
            last_next    = final_beat;
            idx_next     = final_beat ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        row_end_reg <= row_end_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_row_end  = row_end_reg;
    assign m_last     = last_reg;

endmodule

`default_nettype wire

// File: src/bmp_row_color_depth_converter.sv
// bmp_row_color_depth_converter: bgr888 <-> rgb555 bmp pixel array converter
// a byte completing a pixel goes into the pixel queue, then its first result beat
// is registered in the back part; throughput: one source byte per cycle while the
// 4-entry pixel queue has room; back part sends one result beat per cycle while
// m_ready is high; 555 to 888 makes 3 bytes (plus row padding) per 2 source bytes
// reset: synchronous active low; mode 0, width 1, row restarted, queue emptied
`timescale 1ns / 1ps
`default_nettype none

module bmp_row_color_depth_converter #(
    parameter int MAX_WIDTH = bmpcdc_pkg::MAX_WIDTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr_en,
    input  wire  [bmpcdc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire  [bmpcdc_pkg::WIDTH_BITS-1:0]    cfg_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [7:0]                           s_in_byte,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [7:0]                           m_out_byte,
    output logic                                 m_row_end,
    output logic                                 m_last
);

    logic             q_full;
    logic             q_push;
    bmpcdc_pkg::job_t q_job;
    logic             q_pop;
    logic             q_head_valid;
    bmpcdc_pkg::job_t q_head_job;

    bmpcdc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    bmpcdc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    bmpcdc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_row_end  (m_row_end),
        .m_last     (m_last)
    );

endmodule

`default_nettype wire
